### rtl/adr_pkg.sv
package adr_pkg;

    localparam int REGIONS_PER_TABLE = 16;
    localparam int NUM_TABLES        = 3;
    localparam int IDX_W = (REGIONS_PER_TABLE > 1) ? $clog2(REGIONS_PER_TABLE) : 1;
    localparam int CNT_W = $clog2(REGIONS_PER_TABLE + 1);
    localparam int SEL_W = 2;

    localparam logic       CMD_INSERT = 1'b0;
    localparam logic       CMD_ACCESS = 1'b1;

    localparam logic [1:0] MAP_READ   = 2'd0;
    localparam logic [1:0] MAP_WRITE  = 2'd1;
    localparam logic [1:0] MAP_INSTR  = 2'd2;
    localparam logic [1:0] MAP_NONE   = 2'd3;

    localparam logic [1:0] SIZE_BYTE  = 2'd0;
    localparam logic [1:0] SIZE_HALF  = 2'd1;

    localparam logic [31:0] FILL_WORD = 32'hCCCC_CCCC;

    typedef enum logic [2:0] {
        ST_MEM_HIT     = 3'd0,
        ST_HANDLER_HIT = 3'd1,
        ST_UNMAPPED    = 3'd2,
        ST_INSERTED    = 3'd3,
        ST_REJECTED    = 3'd4
    } t_status;

    typedef struct packed {
        logic        command;
        logic [1:0]  map_select;
        logic [31:0] address;
        logic [31:0] region_end;
        logic        region_is_handler;
        logic [1:0]  access_size;
        logic [31:0] write_data;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic [3:0]  region_index;
        logic [31:0] offset;
        logic [31:0] access_data;
    } t_out_item;

    // Scan token handed from cell to cell
    typedef struct packed {
        logic             valid;
        logic             decided;
        logic             hit;
        logic             kind;
        logic [IDX_W-1:0] idx;
        logic [31:0]      start;
    } t_tok;

    // Region write broadcast to every cell
    typedef struct packed {
        logic             en;
        logic [SEL_W-1:0] tbl;
        logic [IDX_W-1:0] idx;
        logic [31:0]      start;
        logic [31:0]      last;
        logic             kind;
    } t_wr;

    function automatic logic [31:0] size_mask(input logic [1:0] size);
        logic [31:0] m;
        case (size)
            SIZE_BYTE: m = 32'h0000_00FF;
            SIZE_HALF: m = 32'h0000_FFFF;
            default:   m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

endpackage

### rtl/adr_if.sv
interface adr_in_if import adr_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface adr_out_if import adr_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/address_region_decoder_core.sv
// channel | dir | handshake     | payload
// i_in    | in  | valid / ready | command, map_select, address, region_end,
//         |     |               | region_is_handler, access_size, write_data
// o_out   | out | valid / ready | status, region_index, offset, access_data
//
// Each item walks a row of REGIONS_PER_TABLE cells, one cell a cycle; the token that
// leaves the last cell is held until its result is registered; the row holds one
// item at a time and the next item is taken the cycle after the result is
// registered. i_rst_n (synchronous, active low) empties all three tables.
// A stalled result waits in the output register; a second finished scan holds
// at the end of the row until that register frees.
module address_region_decoder_core import adr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    adr_in_if.sink    i_in,
    adr_out_if.source o_out
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    t_state           r_state;
    t_state           n_state;
    t_in_item         r_item;
    logic             r_go;
    t_tok             r_fin;
    logic [CNT_W-1:0] r_cnt [NUM_TABLES];
    logic             r_out_valid;
    t_out_item        r_out;
    t_out_item        n_out;

    t_tok             tok [REGIONS_PER_TABLE+1];
    t_wr              wr;
    logic             sel_ok;
    logic [SEL_W-1:0] tbl;
    logic [CNT_W-1:0] cnt_sel;
    logic             accept;
    logic             commit;
    logic             found;
    logic             acc_hit;
    logic             ins_ok;
    logic [31:0]      mask;
    logic [IDX_W+3:0] idx_ext;
    logic [CNT_W+3:0] cnt_ext;

    assign sel_ok  = r_item.map_select != MAP_NONE;
    assign tbl     = sel_ok ? r_item.map_select : MAP_READ;
    assign cnt_sel = sel_ok ? r_cnt[tbl] : '0;

    assign accept  = i_in.valid && (r_state == S_IDLE);
    assign commit  = (r_state == S_FIN) && (!r_out_valid || o_out.ready);

    assign tok[0] = '{valid: r_go, decided: 1'b0, hit: 1'b0, kind: 1'b0,
                      idx: '0, start: '0};

    for (genvar g = 0; g < REGIONS_PER_TABLE; g++) begin : g_cell
        adr_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (IDX_W'(g)),
            .i_tbl   (tbl),
            .i_cnt   (cnt_sel),
            .i_addr  (r_item.address),
            .i_tok   (tok[g]),
            .i_wr    (wr),
            .o_tok   (tok[g+1])
        );
    end

    // Result of the finished scan
    always_comb begin
        found   = r_fin.decided && r_fin.hit;
        acc_hit = found && !((tbl == MAP_INSTR) && r_fin.kind);
        ins_ok  = sel_ok && (cnt_sel < CNT_W'(REGIONS_PER_TABLE)) && !found;
        mask    = size_mask(r_item.access_size);
        idx_ext = {4'b0, r_fin.idx};
        cnt_ext = {4'b0, cnt_sel};

        n_out.status       = ST_UNMAPPED;
        n_out.region_index = '0;
        n_out.offset       = '0;
        n_out.access_data  = '0;

        if (r_item.command == CMD_INSERT) begin
            if (ins_ok) begin
                n_out.status       = ST_INSERTED;
                n_out.region_index = cnt_ext[3:0];
            end else begin
                n_out.status       = ST_REJECTED;
            end
        end else if (sel_ok) begin
            if (acc_hit) begin
                n_out.status       = r_fin.kind ? ST_HANDLER_HIT : ST_MEM_HIT;
                n_out.region_index = idx_ext[3:0];
                n_out.offset       = r_item.address - r_fin.start;
                if (tbl == MAP_WRITE) begin
                    n_out.access_data = r_item.write_data & mask;
                end
            end else if (tbl != MAP_WRITE) begin
                n_out.access_data = FILL_WORD & mask;
            end
        end

        wr.en    = commit && (r_item.command == CMD_INSERT) && ins_ok;
        wr.tbl   = tbl;
        wr.idx   = cnt_sel[IDX_W-1:0];
        wr.start = r_item.address;
        wr.last  = r_item.region_end;
        wr.kind  = r_item.region_is_handler;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (tok[REGIONS_PER_TABLE].valid) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (commit) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_go        <= 1'b0;
            r_out_valid <= 1'b0;
            for (int t = 0; t < NUM_TABLES; t++) begin
                r_cnt[t] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_go    <= accept;
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (wr.en) begin
                r_cnt[tbl] <= cnt_sel + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_in.data;
        end
        // hold the token that leaves the row
        if ((r_state == S_SCAN) && tok[REGIONS_PER_TABLE].valid) begin
            r_fin <= tok[REGIONS_PER_TABLE];
        end
        if (commit) begin
            r_out <= n_out;
        end
    end

    assign i_in.ready  = r_state == S_IDLE;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

endmodule

### rtl/adr_cell.sv
module adr_cell import adr_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IDX_W-1:0] i_index,
    input  logic [SEL_W-1:0] i_tbl,
    input  logic [CNT_W-1:0] i_cnt,
    input  logic [31:0]      i_addr,
    input  t_tok             i_tok,
    input  t_wr              i_wr,
    output t_tok             o_tok
);

    logic [31:0] r_start [NUM_TABLES];
    logic [31:0] r_last  [NUM_TABLES];
    logic        r_kind  [NUM_TABLES];
    t_tok        r_tok;
    t_tok        n_tok;
    logic        entry_ok;
    logic [31:0] cur_start;
    logic [31:0] cur_last;
    logic        cur_kind;

    assign entry_ok  = CNT_W'(i_index) < i_cnt;
    assign cur_start = r_start[i_tbl];
    assign cur_last  = r_last[i_tbl];
    assign cur_kind  = r_kind[i_tbl];

    always_comb begin
        n_tok = i_tok;
        // first live region whose last address covers the access decides
        if (i_tok.valid && !i_tok.decided && entry_ok && (i_addr <= cur_last)) begin
            n_tok.decided = 1'b1;
            n_tok.hit     = i_addr >= cur_start;
            n_tok.kind    = cur_kind;
            n_tok.idx     = i_index;
            n_tok.start   = cur_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok.valid <= n_tok.valid;
        end
        r_tok.decided <= n_tok.decided;
        r_tok.hit     <= n_tok.hit;
        r_tok.kind    <= n_tok.kind;
        r_tok.idx     <= n_tok.idx;
        r_tok.start   <= n_tok.start;
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en && (i_wr.idx == i_index)) begin
            r_start[i_wr.tbl] <= i_wr.start;
            r_last[i_wr.tbl]  <= i_wr.last;
            r_kind[i_wr.tbl]  <= i_wr.kind;
        end
    end

    assign o_tok = r_tok;

endmodule
